/* design/mcrb_pkg.sv */
// Shared types and constants for the multichannel overwrite ring buffer.
package mcrb_pkg;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 6;
    localparam int WORD_W   = 64;
    localparam int IO_CH    = 4;
    localparam int OCC_W    = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT,
        ACT_GET,
        ACT_LOOK,
        ACT_CLEAR
    } t_action;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic             data_valid;
        logic [OCC_W-1:0] occupancy;
        logic             is_full;
        logic             is_empty;
    } t_status;

endpackage

/* design/mcrb_slot_ram.sv */
// Slot memory: one write port, one read port with registered read data.
module mcrb_slot_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/mcrb_ctrl.sv */
// Pointer and flag control: decodes the action, drives the slot memory, registers status.
module mcrb_ctrl import mcrb_pkg::*; #(
    parameter int DEPTH = 64,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = PTR_W + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_action            i_action,
    input  logic [INDEX_W-1:0] i_index,
    output logic               o_wr_en,
    output logic [PTR_W-1:0]   o_wr_addr,
    output logic               o_rd_en,
    output logic [PTR_W-1:0]   o_rd_addr,
    output logic               o_strobe,
    output t_status            o_status
);

    localparam int IDX_N = 2 ** INDEX_W;

    typedef logic [PTR_W-1:0] t_mod_tab [IDX_N];

    // index reduced modulo DEPTH, built at elaboration
    function automatic t_mod_tab build_mod_tab();
        t_mod_tab tab;
        for (int i = 0; i < IDX_N; i++) begin
            tab[i] = PTR_W'(i % DEPTH);
        end
        return tab;
    endfunction

    localparam t_mod_tab MOD_TAB = build_mod_tab();

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic             r_full, n_full;
    logic             r_strobe;
    t_status          r_status, n_status;

    logic             empty;
    logic             valid;
    logic [CNT_W-1:0] look_sum;
    logic [PTR_W-1:0] look_addr;
    logic [CNT_W-1:0] diff;
    logic [CNT_W-1:0] occ;

    assign empty = !r_full && (r_wr == r_rd);

    assign look_sum  = {1'b0, r_rd} + {1'b0, MOD_TAB[i_index]};
    assign look_addr = (look_sum >= CNT_W'(DEPTH)) ? PTR_W'(look_sum - CNT_W'(DEPTH))
                                                   : look_sum[PTR_W-1:0];

    always_comb begin
        n_wr      = r_wr;
        n_rd      = r_rd;
        n_full    = r_full;
        o_wr_en   = 1'b0;
        o_rd_en   = 1'b0;
        o_rd_addr = r_rd;
        valid     = 1'b0;
        if (i_accept) begin
            case (i_action)
                ACT_PUT: begin
                    o_wr_en = 1'b1;
                    if (r_full) begin
                        n_rd = ptr_inc(r_rd);
                    end
                    n_wr   = ptr_inc(r_wr);
                    n_full = (ptr_inc(r_wr) == n_rd);
                end
                ACT_GET: begin
                    if (!empty) begin
                        valid   = 1'b1;
                        o_rd_en = 1'b1;
                        n_full  = 1'b0;
                        n_rd    = ptr_inc(r_rd);
                    end
                end
                ACT_LOOK: begin
                    if (!empty) begin
                        valid     = 1'b1;
                        o_rd_en   = 1'b1;
                        o_rd_addr = look_addr;
                    end
                end
                ACT_CLEAR: begin
                    n_wr   = r_rd;
                    n_full = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_wr_addr = r_wr;

    // occupancy after the action; a borrow means the write pointer has wrapped
    assign diff = {1'b0, n_wr} - {1'b0, n_rd};
    assign occ  = n_full ? CNT_W'(DEPTH)
                         : (diff[CNT_W-1] ? diff + CNT_W'(DEPTH) : diff);

    always_comb begin
        n_status.data_valid = valid;
        n_status.occupancy  = OCC_W'(occ);
        n_status.is_full    = n_full;
        n_status.is_empty   = !n_full && (n_wr == n_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_full   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_wr     <= n_wr;
            r_rd     <= n_rd;
            r_full   <= n_full;
            r_strobe <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_status <= n_status;
        end
    end

    assign o_strobe = r_strobe;
    assign o_status = r_status;

`ifndef ASSERT_OFF
    a_full_ptrs_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_wr == r_rd))
        else $error("full flag set with unequal pointers");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_strobe)
        else $error("accepted word produced no result");

    a_valid_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status.data_valid) |-> $past(!empty))
        else $error("data returned from an empty buffer");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status.is_full) |-> (r_status.occupancy == OCC_W'(DEPTH)))
        else $error("full status with wrong occupancy");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status.is_empty) |-> (r_status.occupancy == '0))
        else $error("empty status with nonzero occupancy");
`endif

endmodule

/* design/multichannel_overwrite_ring_buffer.sv */
// Multichannel ring buffer with overwrite on full: top level.
//
// Command port: a word is taken at a rising edge with start high and busy low.
// i_action selects put, get, look (at i_index slots past the oldest) or clear.
// Put stores i_sample_0..3 at the head; when full the oldest slot is dropped.
// Every accepted word yields exactly one result, shown for one cycle with
// o_strobe high, in the cycle after acceptance. o_data_* carry the slot read by
// get or look (zero otherwise), o_data_valid flags it, and o_occupancy,
// o_is_full, o_is_empty give the state after the action.
// Throughput is one word per cycle: pointer update and the single slot
// memory access (one write port, one registered read port) finish in the
// accepting cycle. The result port has no back pressure.
// busy is high only while reset is held. Reset empties the buffer at once;
// slot contents are not cleared, so a look beyond the filled slots at a slot
// never written returns undefined data.
module multichannel_overwrite_ring_buffer import mcrb_pkg::*; #(
    parameter int DEPTH    = 64,
    parameter int CHANNELS = 4,
    localparam int PTR_W = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [INDEX_W-1:0] i_index,
    input  logic [WORD_W-1:0]  i_sample_0,
    input  logic [WORD_W-1:0]  i_sample_1,
    input  logic [WORD_W-1:0]  i_sample_2,
    input  logic [WORD_W-1:0]  i_sample_3,
    output logic               o_strobe,
    output logic [WORD_W-1:0]  o_data_0,
    output logic [WORD_W-1:0]  o_data_1,
    output logic [WORD_W-1:0]  o_data_2,
    output logic [WORD_W-1:0]  o_data_3,
    output logic               o_data_valid,
    output logic [OCC_W-1:0]   o_occupancy,
    output logic               o_is_full,
    output logic               o_is_empty
);

    localparam int SLOT_W = CHANNELS * WORD_W;

    logic              accept;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [SLOT_W-1:0] wr_data;
    logic [SLOT_W-1:0] rd_data;
    t_status           status;
    t_word             samples  [IO_CH];
    t_word             data_out [IO_CH];

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    assign samples[0] = i_sample_0;
    assign samples[1] = i_sample_1;
    assign samples[2] = i_sample_2;
    assign samples[3] = i_sample_3;

    // channels past the port count store zero
    for (genvar c = 0; c < CHANNELS; c++) begin : g_wr
        if (c < IO_CH) begin : g_io
            assign wr_data[c*WORD_W +: WORD_W] = samples[c];
        end else begin : g_pad
            assign wr_data[c*WORD_W +: WORD_W] = '0;
        end
    end

    mcrb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_action  (t_action'(i_action)),
        .i_index   (i_index),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_strobe  (o_strobe),
        .o_status  (status)
    );

    mcrb_slot_ram #(
        .DEPTH (DEPTH),
        .WIDTH (SLOT_W)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    for (genvar j = 0; j < IO_CH; j++) begin : g_rd
        if (j < CHANNELS) begin : g_ch
            assign data_out[j] = status.data_valid ? rd_data[j*WORD_W +: WORD_W] : '0;
        end else begin : g_none
            assign data_out[j] = '0;
        end
    end

    assign o_data_0     = data_out[0];
    assign o_data_1     = data_out[1];
    assign o_data_2     = data_out[2];
    assign o_data_3     = data_out[3];
    assign o_data_valid = status.data_valid;
    assign o_occupancy  = status.occupancy;
    assign o_is_full    = status.is_full;
    assign o_is_empty   = status.is_empty;

endmodule

/* verif/ring_buffer_checker.sv */
// Watches the command and result ports of the ring buffer, predicts and compares.
module ring_buffer_checker import mcrb_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [INDEX_W-1:0]  i_index,
    input  t_word               i_sample_0,
    input  t_word               i_sample_1,
    input  t_word               i_sample_2,
    input  t_word               i_sample_3,
    input  logic                i_strobe,
    input  t_word               i_data_0,
    input  t_word               i_data_1,
    input  t_word               i_data_2,
    input  t_word               i_data_3,
    input  logic                i_data_valid,
    input  logic [OCC_W-1:0]    i_occupancy,
    input  logic                i_is_full,
    input  logic                i_is_empty,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [IO_CH-1:0][WORD_W-1:0] data;
        logic                         valid;
        logic [OCC_W-1:0]             occ;
        logic                         full;
        logic                         empty;
    } t_ring_result;

    t_word        slot_words [DEPTH][IO_CH];
    int           head_ptr;
    int           tail_ptr;
    logic         ring_full;
    t_ring_result expected_results [$];

    initial begin
        head_ptr     = 0;
        tail_ptr     = 0;
        ring_full    = 1'b0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        o_fail_count++;
        $display("tb: %s mismatch at %0t: got %h, want %h", what, $realtime, got, want);
    endtask

    // Applies one accepted command to the shadow ring and returns its result.
    task automatic ring_step(input t_action act, input logic [INDEX_W-1:0] idx,
                             input logic [IO_CH-1:0][WORD_W-1:0] words,
                             output t_ring_result res);
        logic was_empty;
        int   used;
        res       = '0;
        was_empty = !ring_full && (head_ptr == tail_ptr);
        case (act)
            ACT_PUT: begin
                for (int c = 0; c < IO_CH; c++)
                    slot_words[head_ptr][c] = words[c];
                if (ring_full)
                    tail_ptr = (tail_ptr + 1) % DEPTH;
                head_ptr  = (head_ptr + 1) % DEPTH;
                ring_full = (head_ptr == tail_ptr);
            end
            ACT_GET: begin
                if (!was_empty) begin
                    for (int c = 0; c < IO_CH; c++)
                        res.data[c] = slot_words[tail_ptr][c];
                    res.valid = 1'b1;
                    ring_full = 1'b0;
                    tail_ptr  = (tail_ptr + 1) % DEPTH;
                end
            end
            ACT_LOOK: begin
                // offset wraps around the ring; stale slots are still returned
                if (!was_empty) begin
                    for (int c = 0; c < IO_CH; c++)
                        res.data[c] = slot_words[(tail_ptr + int'(idx)) % DEPTH][c];
                    res.valid = 1'b1;
                end
            end
            ACT_CLEAR: begin
                head_ptr  = tail_ptr;
                ring_full = 1'b0;
            end
            default: ;
        endcase
        used      = ring_full ? DEPTH : (head_ptr - tail_ptr + DEPTH) % DEPTH;
        res.occ   = used[OCC_W-1:0];
        res.full  = ring_full;
        res.empty = !ring_full && (head_ptr == tail_ptr);
    endtask

    always @(posedge i_clk) begin
        t_ring_result want;
        t_ring_result fresh;
        logic [IO_CH-1:0][WORD_W-1:0] got_data;
        if (i_rst_n) begin
            // the older result is retired before a new word is predicted
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending", '0, '0);
                end else begin
                    want     = expected_results.pop_front();
                    got_data = {i_data_3, i_data_2, i_data_1, i_data_0};
                    for (int c = 0; c < IO_CH; c++)
                        if (got_data[c] !== want.data[c])
                            report_mismatch($sformatf("data_%0d", c), got_data[c], want.data[c]);
                    if (i_data_valid !== want.valid)
                        report_mismatch("data_valid", t_word'(i_data_valid), t_word'(want.valid));
                    if (i_occupancy !== want.occ)
                        report_mismatch("occupancy", t_word'(i_occupancy), t_word'(want.occ));
                    if (i_is_full !== want.full)
                        report_mismatch("is_full", t_word'(i_is_full), t_word'(want.full));
                    if (i_is_empty !== want.empty)
                        report_mismatch("is_empty", t_word'(i_is_empty), t_word'(want.empty));
                end
            end
            if (i_start && !i_busy) begin
                ring_step(t_action'(i_action), i_index,
                          {i_sample_3, i_sample_2, i_sample_1, i_sample_0}, fresh);
                expected_results.push_back(fresh);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

/* verif/multichannel_overwrite_ring_buffer_test.sv */
// Stimulus and verdict for the multichannel overwrite ring buffer.
module multichannel_overwrite_ring_buffer_test;
    import mcrb_pkg::*;

    localparam int SLOTS       = 64;
    localparam int RAND_WORDS  = 1350;
    localparam int CYCLE_LIMIT = 100000;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [ACTION_W-1:0] i_action;
    logic [INDEX_W-1:0]  i_index;
    t_word               i_sample_0;
    t_word               i_sample_1;
    t_word               i_sample_2;
    t_word               i_sample_3;
    logic                o_strobe;
    t_word               o_data_0;
    t_word               o_data_1;
    t_word               o_data_2;
    t_word               o_data_3;
    logic                o_data_valid;
    logic [OCC_W-1:0]    o_occupancy;
    logic                o_is_full;
    logic                o_is_empty;
    int                  fail_count;
    int                  pending;

    // stimulus-side view of the pointers, used only to steer look offsets
    int   sent_count;
    int   idle_pct;
    int   cycle_count;
    int   trk_head;
    int   trk_tail;
    bit   trk_full;
    bit   written [SLOTS];

    multichannel_overwrite_ring_buffer #(
        .DEPTH    (SLOTS),
        .CHANNELS (IO_CH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_index      (i_index),
        .i_sample_0   (i_sample_0),
        .i_sample_1   (i_sample_1),
        .i_sample_2   (i_sample_2),
        .i_sample_3   (i_sample_3),
        .o_strobe     (o_strobe),
        .o_data_0     (o_data_0),
        .o_data_1     (o_data_1),
        .o_data_2     (o_data_2),
        .o_data_3     (o_data_3),
        .o_data_valid (o_data_valid),
        .o_occupancy  (o_occupancy),
        .o_is_full    (o_is_full),
        .o_is_empty   (o_is_empty)
    );

    ring_buffer_checker #(
        .DEPTH (SLOTS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_action     (i_action),
        .i_index      (i_index),
        .i_sample_0   (i_sample_0),
        .i_sample_1   (i_sample_1),
        .i_sample_2   (i_sample_2),
        .i_sample_3   (i_sample_3),
        .i_strobe     (o_strobe),
        .i_data_0     (o_data_0),
        .i_data_1     (o_data_1),
        .i_data_2     (o_data_2),
        .i_data_3     (o_data_3),
        .i_data_valid (o_data_valid),
        .i_occupancy  (o_occupancy),
        .i_is_full    (o_is_full),
        .i_is_empty   (o_is_empty),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int ring_used();
        return trk_full ? SLOTS : (trk_head - trk_tail + SLOTS) % SLOTS;
    endfunction

    // Random look offset; while the ring holds data it never lands on a slot that was never written.
    function automatic logic [INDEX_W-1:0] pick_look_index();
        int idx;
        idx = $urandom_range(0, SLOTS - 1);
        if (ring_used() != 0 && !written[(trk_tail + idx) % SLOTS])
            idx = $urandom_range(0, ring_used() - 1);
        return idx[INDEX_W-1:0];
    endfunction

    // Drives one word at the falling edge and holds it until taken.
    task automatic send(input t_action act, input logic [INDEX_W-1:0] idx,
                        input t_word s0, input t_word s1, input t_word s2, input t_word s3);
        // each cycle idles with probability idle_pct percent
        while ($urandom_range(1, 100) <= idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_action   <= act;
        i_index    <= idx;
        i_sample_0 <= s0;
        i_sample_1 <= s1;
        i_sample_2 <= s2;
        i_sample_3 <= s3;
        do @(posedge i_clk); while (busy);
        sent_count++;
        case (act)
            ACT_PUT: begin
                written[trk_head] = 1'b1;
                if (trk_full)
                    trk_tail = (trk_tail + 1) % SLOTS;
                trk_head = (trk_head + 1) % SLOTS;
                trk_full = (trk_head == trk_tail);
            end
            ACT_GET: begin
                if (ring_used() != 0) begin
                    trk_tail = (trk_tail + 1) % SLOTS;
                    trk_full = 1'b0;
                end
            end
            ACT_CLEAR: begin
                trk_head = trk_tail;
                trk_full = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic send_rand(input t_action act);
        logic [INDEX_W-1:0] idx;
        idx = (act == ACT_LOOK) ? pick_look_index() : INDEX_W'($urandom);
        send(act, idx, rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int      run_len;
        int      pick;
        t_action act;
        start      = 1'b0;
        i_rst_n    = 1'b0;
        i_action   = ACT_PUT;
        i_index    = '0;
        i_sample_0 = '0;
        i_sample_1 = '0;
        i_sample_2 = '0;
        i_sample_3 = '0;
        sent_count = 0;
        idle_pct   = 26;
        trk_head   = 0;
        trk_tail   = 0;
        trk_full   = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty ring, extremes, wrap of look past the filled slots, clear
        send(ACT_GET,   '0, '0, '0, '0, '0);
        send(ACT_LOOK,  '1, '1, '1, '1, '1);
        send(ACT_LOOK,  '0, '0, '0, '0, '0);
        send(ACT_CLEAR, '0, '0, '0, '0, '0);
        send(ACT_PUT,   '0, '0, '0, '0, '0);
        send(ACT_PUT,   '1, '1, '1, '1, '1);
        send(ACT_PUT,   '0, {32{2'b01}}, {32{2'b10}}, {32{2'b01}}, {32{2'b10}});
        send(ACT_LOOK,  6'd0, '0, '0, '0, '0);
        send(ACT_LOOK,  6'd2, '0, '0, '0, '0);
        send(ACT_GET,   '0, '0, '0, '0, '0);
        send(ACT_LOOK,  6'd63, '0, '0, '0, '0);   // wraps back to the stale slot 0
        send(ACT_LOOK,  6'd1, '0, '0, '0, '0);
        send(ACT_GET,   '0, '0, '0, '0, '0);
        send(ACT_GET,   '0, '0, '0, '0, '0);
        send(ACT_GET,   '1, '1, '1, '1, '1);
        send(ACT_LOOK,  '0, '0, '0, '0, '0);
        send_rand(ACT_PUT);
        send_rand(ACT_PUT);
        send(ACT_CLEAR, '0, '0, '0, '0, '0);
        send(ACT_LOOK,  '0, '0, '0, '0, '0);
        send(ACT_GET,   '0, '0, '0, '0, '0);
        send(ACT_PUT,   '0, {32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}});
        send(ACT_LOOK,  '0, '0, '0, '0, '0);

        // random runs: fill past full, drain past empty, look bursts, mixed traffic
        sent_count = 0;
        while (sent_count < RAND_WORDS) begin
            if (sent_count >= RAND_WORDS / 3 && idle_pct == 26) begin
                wait_idle();
                idle_pct = 77;
            end else if (sent_count >= 2 * RAND_WORDS / 3 && idle_pct == 77) begin
                wait_idle();
                idle_pct = 0;
            end
            pick = $urandom_range(0, 9);
            if (pick <= 2) begin
                run_len = $urandom_range(1, 90);
                repeat (run_len) send_rand(ACT_PUT);
            end else if (pick <= 4) begin
                run_len = $urandom_range(1, 70);
                repeat (run_len) send_rand(ACT_GET);
            end else if (pick <= 6) begin
                run_len = $urandom_range(1, 20);
                repeat (run_len) send_rand(ACT_LOOK);
            end else begin
                run_len = $urandom_range(1, 20);
                repeat (run_len) begin
                    pick = $urandom_range(1, 100);
                    if (pick <= 40)      act = ACT_PUT;
                    else if (pick <= 65) act = ACT_GET;
                    else if (pick <= 96) act = ACT_LOOK;
                    else                 act = ACT_CLEAR;
                    send_rand(act);
                end
            end
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
design/mcrb_pkg.sv
design/mcrb_slot_ram.sv
design/mcrb_ctrl.sv
design/multichannel_overwrite_ring_buffer.sv
verif/ring_buffer_checker.sv
verif/multichannel_overwrite_ring_buffer_test.sv
